[rtl/sbm_pkg.sv]
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared widths, constants and lane control type for the SAD block matcher.
// ----------------------------------------------------------------------------
package sbm_pkg;

	localparam int REF_W  = 20;
	localparam int TGT_W  = 44;
	localparam int SAD_W  = 15;
	localparam int FLOW_W = 6;
	localparam int SUM_W  = 16;
	localparam int COL_W  = 8;

	localparam logic [SUM_W-1:0]  NO_SAD  = 16'h7fff;
	localparam logic [FLOW_W-1:0] NO_FLOW = 6'h3f;

	typedef struct packed {
		logic load;
		logic step;
		logic first;
		logic sub;
	} lane_ctl_t;

endpackage

[rtl/sbm_in_if.sv]
// ----------------------------------------------------------------------------
// sbm_in_if
// Column request channel: reference column and target column.
// ----------------------------------------------------------------------------
interface sbm_in_if;

	logic                      valid;
	logic                      ready;
	logic [sbm_pkg::REF_W-1:0] ref_column;
	logic [sbm_pkg::TGT_W-1:0] target_column;

	modport source(output valid, output ref_column, output target_column, input ready);
	modport sink(input valid, input ref_column, input target_column, output ready);

endinterface

[rtl/sbm_out_if.sv]
// ----------------------------------------------------------------------------
// sbm_out_if
// Result request channel: best windowed SAD and flow code of a group.
// ----------------------------------------------------------------------------
interface sbm_out_if;

	logic                       valid;
	logic                       ready;
	logic [sbm_pkg::SAD_W-1:0]  best_sad;
	logic [sbm_pkg::FLOW_W-1:0] flow_code;

	modport source(output valid, output best_sad, output flow_code, input ready);
	modport sink(input valid, input best_sad, input flow_code, output ready);

endinterface

[rtl/sad_block_match_min_search.sv]
// ----------------------------------------------------------------------------
// sad_block_match_min_search
// Windowed SAD block matching with minimum search over vertical offsets.
// ----------------------------------------------------------------------------
// Usage:
//   columns: one request per column, groups of BLOCK+2*SEARCH columns.
//   results: one request per group, after its last column, carrying the
//            smallest windowed SAD and its flow code.
//   Throughput is one column per cycle while columns.ready is high; one
//   lane per vertical offset forms the column SAD and its sliding window sum.
//   A result is valid after the last column of its group passes the column
//   SAD stage, the window stage and the merge stage.
//   The result register holds a finished result while the receiver stalls;
//   columns keep flowing until the last column of the next group reaches
//   the merge stage, then columns.ready drops until the result is taken.
//   Reset clears the column count, the pipeline valids, the running best
//   and the result valid; the block then waits for the first column
//   of a fresh group. Column history needs no clearing.
// ----------------------------------------------------------------------------
module sad_block_match_min_search #(
	parameter int BLOCK      = 5,
	parameter int SEARCH     = 3,
	parameter int PIXEL_BITS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	sbm_in_if.sink    columns,
	sbm_out_if.source results
);

	localparam int OFFSETS = 2*SEARCH + 1;
	localparam int GROUP   = BLOCK + 2*SEARCH;
	localparam int CW      = $clog2(GROUP + 1);
	localparam int RP      = BLOCK*PIXEL_BITS;
	localparam int TP      = GROUP*PIXEL_BITS;

	logic [RP+sbm_pkg::REF_W-1:0] ref_wide;
	logic [TP+sbm_pkg::TGT_W-1:0] tgt_wide;
	logic [RP-1:0]                ref_px;
	logic [TP-1:0]                tgt_px;

	logic            accept;
	logic            adv;
	logic            blocked;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   k_in;
	logic            v_s1;
	logic            v_s2;
	logic [CW-1:0]   k_s1;
	logic [CW-1:0]   k_s2;
	sbm_pkg::lane_ctl_t        ctl;
	logic [sbm_pkg::SUM_W-1:0] win [OFFSETS];

	assign ref_wide = {RP'(0), columns.ref_column};
	assign tgt_wide = {TP'(0), columns.target_column};
	assign ref_px   = ref_wide[RP-1:0];
	assign tgt_px   = tgt_wide[TP-1:0];

	assign blocked = v_s2 && (k_s2 == CW'(GROUP)) && results.valid && !results.ready;
	assign adv     = !blocked;
	assign columns.ready = adv;
	assign accept  = columns.valid && adv;
	assign k_in    = cnt_q + CW'(1);

	assign ctl.load  = accept;
	assign ctl.step  = adv && v_s1;
	assign ctl.first = (k_s1 == CW'(1));
	assign ctl.sub   = (k_s1 > CW'(BLOCK));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else if (adv) begin
			if (accept) begin
				cnt_q <= (k_in == CW'(GROUP)) ? '0 : k_in;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1 <= k_in;
			k_s2 <= k_s1;
		end
	end

	for (genvar i = 0; i < OFFSETS; i++) begin : g_lane
		sbm_lane #(
			.BLOCK      (BLOCK),
			.PIXEL_BITS (PIXEL_BITS)
		) u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.ref_px (ref_px),
			.tgt_px (tgt_px[i*PIXEL_BITS +: RP]),
			.win    (win[i])
		);
	end

	sbm_merge #(
		.BLOCK  (BLOCK),
		.SEARCH (SEARCH)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (adv && v_s2),
		.k         (k_s2),
		.win       (win),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.best_sad  (results.best_sad),
		.flow_code (results.flow_code)
	);

endmodule

[rtl/sbm_lane.sv]
// ----------------------------------------------------------------------------
// sbm_lane
// One vertical offset: column SAD, column history and sliding window sum.
// ----------------------------------------------------------------------------
module sbm_lane #(
	parameter int BLOCK      = 5,
	parameter int PIXEL_BITS = 4
) (
	input  logic                            clk,
	input  sbm_pkg::lane_ctl_t              ctl,
	input  logic [BLOCK*PIXEL_BITS-1:0]     ref_px,
	input  logic [BLOCK*PIXEL_BITS-1:0]     tgt_px,
	output logic [sbm_pkg::SUM_W-1:0]       win
);

	logic [sbm_pkg::COL_W-1:0] col_sad;
	logic [sbm_pkg::COL_W-1:0] col_s1;
	logic [sbm_pkg::COL_W-1:0] hist_q [BLOCK];
	logic [sbm_pkg::SUM_W-1:0] win_q;
	logic [sbm_pkg::SUM_W-1:0] base;
	logic [sbm_pkg::SUM_W-1:0] drop;

	always_comb begin
		logic [PIXEL_BITS-1:0]     a;
		logic [PIXEL_BITS-1:0]     b;
		logic [PIXEL_BITS-1:0]     d;
		logic [sbm_pkg::COL_W-1:0] acc;
		acc = '0;
		for (int j = 0; j < BLOCK; j++) begin
			a   = ref_px[j*PIXEL_BITS +: PIXEL_BITS];
			b   = tgt_px[j*PIXEL_BITS +: PIXEL_BITS];
			d   = (a >= b) ? (a - b) : (b - a);
			acc = acc + sbm_pkg::COL_W'(d);
		end
		col_sad = acc;
	end

	assign base = ctl.first ? '0 : win_q;
	assign drop = ctl.sub ? sbm_pkg::SUM_W'(hist_q[0]) : '0;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			col_s1 <= col_sad;
		end
		if (ctl.step) begin
			win_q <= base + sbm_pkg::SUM_W'(col_s1) - drop;
			for (int j = 0; j < BLOCK - 1; j++) begin
				hist_q[j] <= hist_q[j+1];
			end
			hist_q[BLOCK-1] <= col_s1;
		end
	end

	assign win = win_q;

endmodule

[rtl/sbm_merge.sv]
// ----------------------------------------------------------------------------
// sbm_merge
// Minimum over the lane window sums, running best and result register.
// ----------------------------------------------------------------------------
module sbm_merge #(
	parameter int BLOCK  = 5,
	parameter int SEARCH = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [$clog2(BLOCK+2*SEARCH+1)-1:0] k,
	input  logic [sbm_pkg::SUM_W-1:0]      win [2*SEARCH+1],
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [sbm_pkg::SAD_W-1:0]      best_sad,
	output logic [sbm_pkg::FLOW_W-1:0]     flow_code
);

	localparam int OFFSETS = 2*SEARCH + 1;
	localparam int GROUP   = BLOCK + 2*SEARCH;
	localparam int CW      = $clog2(GROUP + 1);
	localparam int IW      = $clog2(OFFSETS);

	logic [sbm_pkg::SUM_W-1:0]  minv;
	logic [IW-1:0]              midx;
	logic                       upd;
	logic                       last;
	logic [sbm_pkg::SUM_W-1:0]  nbest;
	logic [sbm_pkg::FLOW_W-1:0] nflow;
	logic [sbm_pkg::SUM_W-1:0]  best_q;
	logic [sbm_pkg::FLOW_W-1:0] flow_q;
	logic                       out_valid_q;
	logic [sbm_pkg::SAD_W-1:0]  sad_q;
	logic [sbm_pkg::FLOW_W-1:0] code_q;

	always_comb begin
		minv = win[0];
		midx = '0;
		for (int i = 1; i < OFFSETS; i++) begin
			if (win[i] < minv) begin
				minv = win[i];
				midx = IW'(i);
			end
		end
	end

	assign upd   = (k >= CW'(BLOCK)) && (minv < best_q);
	assign last  = (k == CW'(GROUP));
	assign nbest = upd ? minv : best_q;
	assign nflow = upd ? {3'(midx), 3'(k - CW'(BLOCK))} : flow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= sbm_pkg::NO_SAD;
			flow_q      <= sbm_pkg::NO_FLOW;
			out_valid_q <= 1'b0;
		end else begin
			if (take && last) begin
				best_q      <= sbm_pkg::NO_SAD;
				flow_q      <= sbm_pkg::NO_FLOW;
				out_valid_q <= 1'b1;
			end else begin
				if (take) begin
					best_q <= nbest;
					flow_q <= nflow;
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			sad_q  <= nbest[sbm_pkg::SAD_W-1:0];
			code_q <= nflow;
		end
	end

	assign out_valid = out_valid_q;
	assign best_sad  = sad_q;
	assign flow_code = code_q;

endmodule

[rtl/sbm_checker.sv]
// ----------------------------------------------------------------------------
// sbm_checker
// Port-level checks for the SAD block matcher, bound to the top level.
// ----------------------------------------------------------------------------
module sbm_checker #(
	parameter int BLOCK      = 5,
	parameter int SEARCH     = 3,
	parameter int PIXEL_BITS = 4
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sbm_pkg::SAD_W-1:0]  best_sad,
	input logic [sbm_pkg::FLOW_W-1:0] flow_code
);

	localparam int MAX_SUM = BLOCK*BLOCK*((1 << PIXEL_BITS) - 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_sad) && $stable(flow_code))
		else $error("result changed while stalled");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("columns stalled without a pending result");

	a_flow_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (flow_code[5:3] <= 3'(2*SEARCH)) && (flow_code[2:0] <= 3'(2*SEARCH)))
		else $error("flow code out of range");

	a_sad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(best_sad) <= 32'(MAX_SUM)))
		else $error("best SAD out of range");

endmodule

bind sad_block_match_min_search sbm_checker #(
	.BLOCK      (BLOCK),
	.SEARCH     (SEARCH),
	.PIXEL_BITS (PIXEL_BITS)
) u_sbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (columns.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.best_sad  (results.best_sad),
	.flow_code (results.flow_code)
);
